>>> rtl/flsc_pkg.sv
// ----------------------------------------------------------------------------
// flsc_pkg
// Shared types and constants of the frequency load-shedding controller.
// ----------------------------------------------------------------------------
package flsc_pkg;

   localparam int NUM_LOADS = 5;
   localparam int CSR_DATA_W = 16;
   localparam int CSR_INDEX_W = 2;
   localparam int TICK_W = 8;

   localparam logic [CSR_INDEX_W-1:0] CSR_FREQUENCY_THRESHOLD = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ROCOF_THRESHOLD     = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_HOLD_TICKS          = 2'd2;

   localparam logic [15:0]       FREQUENCY_THRESHOLD_RESET = 16'd49000;
   localparam logic [14:0]       ROCOF_THRESHOLD_RESET     = 15'd1000;
   localparam logic [TICK_W-1:0] HOLD_TICKS_RESET          = 8'd25;
   localparam logic [TICK_W-1:0] TICK_MAX                  = 8'd255;

   typedef struct packed {
      logic [NUM_LOADS-1:0] requested_loads;
      logic [15:0]          frequency_mhz;
      logic signed [15:0]   rocof_chz;
      logic                 maintenance_toggle;
   } req_type;

   typedef struct packed {
      logic [NUM_LOADS-1:0] allowed_loads;
      logic [NUM_LOADS-1:0] shed_loads;
      logic                 unstable;
      logic                 managing;
      logic                 maintenance_mode;
   } rsp_type;

   typedef struct packed {
      logic [15:0]       frequency_threshold;
      logic [14:0]       rocof_threshold;
      logic [TICK_W-1:0] hold_ticks;
   } cfg_type;

endpackage

>>> rtl/frequency_load_shedding_controller_top.sv
// ----------------------------------------------------------------------------
// frequency_load_shedding_controller_top
// Load-shedding controller with a registered result and a skid stage.
// ----------------------------------------------------------------------------
// One decision tick is taken every cycle while the input does not stall, as set
// by the single decision register stage; its result is registered into the
// output register, or into the skid register while that is full. The two-entry
// result buffer (output register plus skid register) keeps the input open while
// one result waits, and the input stalls only when both entries are full.
module frequency_load_shedding_controller_top import flsc_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_type                req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_type                rsp_data,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data
);

   cfg_type cfg_ff;
   rsp_type result;
   rsp_type out_ff;
   rsp_type skid_ff;
   logic    out_valid_ff;
   logic    skid_valid_ff;
   logic    push;
   logic    pop;

   assign req_stall = skid_valid_ff;
   assign push      = req_valid && !skid_valid_ff;
   assign pop       = out_valid_ff && !rsp_stall;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frequency_threshold <= FREQUENCY_THRESHOLD_RESET;
         cfg_ff.rocof_threshold     <= ROCOF_THRESHOLD_RESET;
         cfg_ff.hold_ticks          <= HOLD_TICKS_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_FREQUENCY_THRESHOLD: cfg_ff.frequency_threshold <= csr_write_data;
            CSR_ROCOF_THRESHOLD:     cfg_ff.rocof_threshold <= csr_write_data[14:0];
            CSR_HOLD_TICKS:          cfg_ff.hold_ticks <= csr_write_data[TICK_W-1:0];
            default: ;
         endcase
      end
   end

   flsc_core u_core (
      .clock  (clock),
      .reset  (reset),
      .accept (push),
      .req    (req_data),
      .cfg    (cfg_ff),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (pop) begin
         if (skid_valid_ff) begin
            out_ff        <= skid_ff;
            skid_valid_ff <= 1'b0;
         end else begin
            out_ff       <= result;
            out_valid_ff <= push;
         end
      end else if (push) begin
         if (!out_valid_ff) begin
            out_ff       <= result;
            out_valid_ff <= 1'b1;
         end else begin
            skid_ff       <= result;
            skid_valid_ff <= 1'b1;
         end
      end
   end

   a_stall_means_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("skid entry held without a pending result beat");

   a_maint_quiet: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.maintenance_mode) |->
         (!rsp_data.unstable && !rsp_data.managing && rsp_data.shed_loads == '0))
      else $error("maintenance result shows shedding activity");

   a_shed_within_allowed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_data.shed_loads & ~rsp_data.allowed_loads) == '0))
      else $error("shed load not in allowed mask");

   a_idle_no_shed: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.managing) |-> (rsp_data.shed_loads == '0))
      else $error("loads shed while not managing");

endmodule

>>> rtl/flsc_core.sv
// ----------------------------------------------------------------------------
// flsc_core
// Decision state and next-state logic: one decision tick per accepted beat.
// ----------------------------------------------------------------------------
module flsc_core import flsc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    accept,
   input  req_type req,
   input  cfg_type cfg,
   output rsp_type result
);

   logic [NUM_LOADS-1:0] allowed_ff, allowed_in;
   logic [NUM_LOADS-1:0] shed_ff, shed_in;
   logic                 managing_ff, managing_in;
   logic                 maint_ff, maint_in;
   logic                 prev_unstable_ff, prev_unstable_in;
   logic [TICK_W-1:0]    ticks_ff, ticks_in;

   logic [15:0]          rocof_abs;
   logic                 unstable;
   logic [NUM_LOADS-1:0] cand;
   logic [NUM_LOADS-1:0] low_bit;
   logic [NUM_LOADS-1:0] high_bit;
   logic [NUM_LOADS-1:0] shed_work;
   logic [NUM_LOADS-1:0] shed_rest;
   logic [TICK_W-1:0]    ticks_inc;

   assign rocof_abs = req.rocof_chz[15] ? (~req.rocof_chz + 16'd1) : req.rocof_chz;

   always_comb begin
      shed_work = shed_ff & req.requested_loads;
      cand      = allowed_ff & req.requested_loads & ~shed_work;
      if (!managing_ff) begin
         cand = req.requested_loads & ~shed_work;
      end
      low_bit = cand & (~cand + NUM_LOADS'(1));
      high_bit = '0;
      for (int i = 0; i < NUM_LOADS; i++) begin
         if (shed_work[i]) begin
            high_bit = '0;
            high_bit[i] = 1'b1;
         end
      end
      shed_rest = shed_work & ~high_bit;
      ticks_inc = (ticks_ff == TICK_MAX) ? ticks_ff : ticks_ff + TICK_W'(1);
   end

   always_comb begin
      maint_in         = maint_ff ^ req.maintenance_toggle;
      allowed_in       = allowed_ff;
      shed_in          = shed_ff;
      managing_in      = managing_ff;
      prev_unstable_in = prev_unstable_ff;
      ticks_in         = ticks_ff;
      unstable         = 1'b0;
      if (maint_in) begin
         managing_in      = 1'b0;
         shed_in          = '0;
         allowed_in       = req.requested_loads;
         prev_unstable_in = 1'b0;
      end else begin
         unstable = (req.frequency_mhz < cfg.frequency_threshold)
                 || (rocof_abs > {1'b0, cfg.rocof_threshold});
         allowed_in = allowed_ff & req.requested_loads;
         shed_in    = shed_work;
         if (!managing_ff) begin
            allowed_in = req.requested_loads;
            if (unstable && (cand != '0)) begin
               shed_in     = shed_work | low_bit;
               managing_in = 1'b1;
               ticks_in    = '0;
            end
         end else if (unstable != prev_unstable_ff) begin
            ticks_in = '0;
         end else if (ticks_inc >= cfg.hold_ticks) begin
            ticks_in = '0;
            if (unstable) begin
               shed_in = shed_work | low_bit;
            end else begin
               shed_in = shed_rest;
               if (shed_rest == '0) begin
                  managing_in = 1'b0;
                  allowed_in  = req.requested_loads;
               end
            end
         end else begin
            ticks_in = ticks_inc;
         end
         prev_unstable_in = unstable;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         allowed_ff       <= '0;
         shed_ff          <= '0;
         managing_ff      <= 1'b0;
         maint_ff         <= 1'b0;
         prev_unstable_ff <= 1'b0;
         ticks_ff         <= '0;
      end else if (accept) begin
         allowed_ff       <= allowed_in;
         shed_ff          <= shed_in;
         managing_ff      <= managing_in;
         maint_ff         <= maint_in;
         prev_unstable_ff <= prev_unstable_in;
         ticks_ff         <= ticks_in;
      end
   end

   always_comb begin
      result.allowed_loads    = allowed_in;
      result.shed_loads       = shed_in;
      result.unstable         = unstable;
      result.managing         = managing_in;
      result.maintenance_mode = maint_in;
   end

endmodule

>>> verif/frequency_load_shedding_controller_top_tb.sv
// ----------------------------------------------------------------------------
// frequency_load_shedding_controller_top_tb
// Self-checking bench for the frequency load-shedding controller.
// ----------------------------------------------------------------------------
// Decision ticks are sent on the request channel and every result beat is
// compared against a cycle-free behavioral model of the shed/restore logic.
// The model is advanced as each request beat is accepted. Directed ticks walk
// the threshold edges, shedding and restoring, manual switch-off and
// maintenance mode. Random runs of stable and unstable ticks follow under
// several threshold and hold settings, with random idling on both channels,
// a long result hold-off and sender pauses.
// ----------------------------------------------------------------------------
module frequency_load_shedding_controller_top_tb import flsc_pkg::*; ();

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   req_type                req_data;
   logic                   rsp_valid;
   logic                   rsp_stall;
   rsp_type                rsp_data;
   logic                   csr_write_enable;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_write_data;

   frequency_load_shedding_controller_top dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // controller model state and settings
   logic [15:0]          cfg_freq_min;
   logic [14:0]          cfg_rocof_max;
   logic [TICK_W-1:0]    cfg_hold;
   logic [NUM_LOADS-1:0] pred_allowed;
   logic [NUM_LOADS-1:0] pred_shed;
   logic                 pred_managing;
   logic                 pred_maint;
   logic                 pred_was_unstable;
   logic [TICK_W-1:0]    pred_hold_count;

   rsp_type expected_decisions[$];
   int      fail_count = 0;
   int      tx_idle_pct = 0;
   int      rx_idle_pct = 0;
   int      rx_hold_request = 0;
   int      rx_hold_left = 0;
   int      rx_stall_left = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int idle_length();
      if ($urandom_range(9) == 0) return $urandom_range(40, 10);
      return $urandom_range(3, 1);
   endfunction

   function automatic int lowest_free(input logic [NUM_LOADS-1:0] on,
                                      input logic [NUM_LOADS-1:0] off);
      for (int i = 0; i < NUM_LOADS; i++)
         if (on[i] && !off[i]) return i;
      return -1;
   endfunction

   function automatic rsp_type predict_decision(input req_type beat);
      rsp_type              r;
      logic [NUM_LOADS-1:0] req;
      logic [NUM_LOADS-1:0] allow;
      logic [NUM_LOADS-1:0] shed;
      logic [15:0]          mag;
      logic                 unst;
      int                   k;
      req = beat.requested_loads;
      mag = beat.rocof_chz[15] ? 16'(-beat.rocof_chz) : beat.rocof_chz;
      unst = 1'b0;
      if (beat.maintenance_toggle) pred_maint = !pred_maint;
      if (pred_maint) begin
         pred_managing = 1'b0;
         pred_shed = '0;
         pred_allowed = req;
         pred_was_unstable = 1'b0;
      end else begin
         allow = pred_allowed & req;
         shed = pred_shed & req;
         unst = (beat.frequency_mhz < cfg_freq_min) || (mag > {1'b0, cfg_rocof_max});
         if (!pred_managing) begin
            allow = req;
            if (unst) begin
               k = lowest_free(allow, shed);
               if (k >= 0) begin
                  shed[k] = 1'b1;
                  pred_managing = 1'b1;
                  pred_hold_count = '0;
               end
            end
         end else if (unst != pred_was_unstable) begin
            pred_hold_count = '0;
         end else begin
            if (pred_hold_count != TICK_MAX) pred_hold_count++;
            if (pred_hold_count >= cfg_hold) begin
               if (unst) begin
                  k = lowest_free(allow, shed);
                  if (k >= 0) shed[k] = 1'b1;
               end else begin
                  k = -1;
                  for (int i = NUM_LOADS - 1; i >= 0 && k < 0; i--)
                     if (shed[i]) k = i;
                  if (k >= 0) shed[k] = 1'b0;
                  if (shed == '0) begin
                     pred_managing = 1'b0;
                     allow = req;
                  end
               end
               pred_hold_count = '0;
            end
         end
         pred_allowed = allow;
         pred_shed = shed;
         pred_was_unstable = unst;
      end
      r.allowed_loads = pred_allowed;
      r.shed_loads = pred_shed;
      r.unstable = unst;
      r.managing = pred_managing;
      r.maintenance_mode = pred_maint;
      return r;
   endfunction

   task automatic offer_tick(input req_type beat);
      int gap = 0;
      if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) gap = idle_length();
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= beat;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_decisions.push_back(predict_decision(beat));
   endtask

   task automatic tick(input logic [NUM_LOADS-1:0] loads, input logic [15:0] freq,
                       input int rocof, input logic toggle);
      req_type b;
      b.requested_loads = loads;
      b.frequency_mhz = freq;
      b.rocof_chz = 16'(rocof);
      b.maintenance_toggle = toggle;
      offer_tick(b);
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_decisions.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic apply_settings(input logic [15:0] freq_min, input logic [14:0] rocof_max,
                                 input logic [TICK_W-1:0] hold);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= CSR_FREQUENCY_THRESHOLD;
      csr_write_data <= freq_min;
      @(negedge clock);
      csr_index <= CSR_ROCOF_THRESHOLD;
      csr_write_data <= {1'b0, rocof_max};
      @(negedge clock);
      csr_index <= CSR_HOLD_TICKS;
      csr_write_data <= {8'd0, hold};
      @(negedge clock);
      csr_write_enable <= 1'b0;
      cfg_freq_min = freq_min;
      cfg_rocof_max = rocof_max;
      cfg_hold = hold;
   endtask

   function automatic req_type make_beat(input bit want_unstable,
                                         input logic [NUM_LOADS-1:0] loads);
      req_type b;
      int lim;
      int v;
      lim = int'(cfg_rocof_max);
      b.requested_loads = loads;
      b.maintenance_toggle = 1'b0;
      b.frequency_mhz = 16'($urandom_range(65535, cfg_freq_min));
      if ($urandom_range(3) == 0) b.frequency_mhz = cfg_freq_min;
      v = int'($urandom_range(2 * lim)) - lim;
      b.rocof_chz = v[15:0];
      if (want_unstable) begin
         if (cfg_freq_min != 0 && $urandom_range(1) == 1) begin
            if ($urandom_range(3) == 0) b.frequency_mhz = cfg_freq_min - 16'd1;
            else b.frequency_mhz = 16'($urandom_range(cfg_freq_min - 16'd1, 0));
            b.rocof_chz = 16'($urandom());
         end else begin
            v = $urandom_range(32768, lim + 1);
            if (v == 32768 || $urandom_range(1) == 1) v = -v;
            b.rocof_chz = v[15:0];
         end
      end
      return b;
   endfunction

   task automatic run_random_ticks(input int count);
      int                   sent = 0;
      int                   len;
      bit                   unst;
      logic [NUM_LOADS-1:0] loads;
      req_type              b;
      while (sent < count) begin
         if ($urandom_range(99) < 12) begin
            b.requested_loads = 5'($urandom());
            b.frequency_mhz = 16'($urandom());
            b.rocof_chz = 16'($urandom());
            b.maintenance_toggle = ($urandom_range(4) == 0);
            offer_tick(b);
            sent++;
         end else begin
            unst = 1'($urandom_range(1));
            len = $urandom_range((cfg_hold > 28) ? 60 : 2 * cfg_hold + 2, 1);
            if (len > count - sent) len = count - sent;
            loads = ($urandom_range(1) == 1) ? 5'h1F : 5'($urandom());
            repeat (len) begin
               b = make_beat(unst, ($urandom_range(9) < 7) ? loads : 5'($urandom()));
               b.maintenance_toggle = ($urandom_range(99) < 2);
               offer_tick(b);
               sent++;
            end
         end
      end
   endtask

   task automatic test_threshold_edges();
      tick(5'h1F, 16'd49000, 0, 1'b0);
      tick(5'h1F, 16'd65535, 1000, 1'b0);
      tick(5'h1F, 16'd65535, -1000, 1'b0);
      tick(5'h1F, 16'd48999, 0, 1'b0);
      tick(5'h1F, 16'd65535, 1001, 1'b0);
      tick(5'h1F, 16'd65535, -32768, 1'b0);
      tick(5'h1F, 16'd0, 32767, 1'b0);
      wait_idle();
   endtask

   task automatic test_shed_restore();
      apply_settings(FREQUENCY_THRESHOLD_RESET, ROCOF_THRESHOLD_RESET, 8'd1);
      repeat (6) tick(5'h1F, 16'd40000, 0, 1'b0);
      repeat (6) tick(5'h1F, 16'd50000, 0, 1'b0);
      tick(5'h1F, 16'd50000, 5000, 1'b0);
      tick(5'h1F, 16'd50000, 5000, 1'b0);
      tick(5'h1C, 16'd50000, -5000, 1'b0);
      tick(5'h00, 16'd50000, 0, 1'b0);
      tick(5'h00, 16'd50000, 0, 1'b0);
      wait_idle();
   endtask

   task automatic test_maintenance();
      tick(5'h0A, 16'd0, 0, 1'b1);
      tick(5'h15, 16'd0, -32768, 1'b0);
      tick(5'h1F, 16'd50000, 0, 1'b1);
      wait_idle();
   endtask

   task automatic test_long_hold();
      apply_settings(16'hFFFF, 15'h7FFF, 8'd255);
      repeat (258) tick(5'h1F, 16'($urandom_range(65534)), 0, 1'b0);
      repeat (258) tick(5'h1F, 16'hFFFF, int'($urandom_range(65534)) - 32767, 1'b0);
      wait_idle();
   endtask

   task automatic test_result_backpressure();
      apply_settings(16'd49000, 15'd1000, 8'd3);
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      rx_hold_request = 150;
      run_random_ticks(30);
      wait_idle();
   endtask

   task automatic test_random_settings();
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: apply_settings(16'd49000, 15'd1000, 8'd25);
            1: apply_settings(16'd0, 15'd0, 8'd1);
            2: apply_settings(16'hFFFF, 15'h7FFF, 8'd255);
            default: apply_settings(($urandom_range(1) == 1) ? 16'($urandom_range(60000, 40000))
                                                            : 16'($urandom()),
                                    ($urandom_range(1) == 1) ? 15'($urandom_range(3000))
                                                            : 15'($urandom()),
                                    8'($urandom_range(8, 1)));
         endcase
         tx_idle_pct = (phase == 1) ? 0 : $urandom_range(40);
         rx_idle_pct = (phase == 1) ? 0 : $urandom_range(40);
         run_random_ticks(12);
         wait_idle();
         run_random_ticks(12);
         wait_idle();
      end
   endtask

   task automatic check_field(input string name, input logic [NUM_LOADS-1:0] want,
                              input logic [NUM_LOADS-1:0] got);
      if (got !== want) begin
         $display("%0t %s mismatch: expected %0h, actual %0h", $time, name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
         if (expected_decisions.size() == 0) begin
            $display("%0t unexpected result beat: expected none, actual %h", $time, rsp_data);
            fail_count++;
         end else begin
            want = expected_decisions.pop_front();
            check_field("allowed_loads", want.allowed_loads, rsp_data.allowed_loads);
            check_field("shed_loads", want.shed_loads, rsp_data.shed_loads);
            check_field("unstable", NUM_LOADS'(want.unstable),
                        NUM_LOADS'(rsp_data.unstable));
            check_field("managing", NUM_LOADS'(want.managing),
                        NUM_LOADS'(rsp_data.managing));
            check_field("maintenance_mode", NUM_LOADS'(want.maintenance_mode),
                        NUM_LOADS'(rsp_data.maintenance_mode));
         end
      end
   end

   always @(negedge clock) begin
      if (rx_hold_request > 0) begin
         rx_hold_left = rx_hold_request;
         rx_hold_request = 0;
      end
      if (rx_hold_left > 0) begin
         rsp_stall <= 1'b1;
         rx_hold_left--;
      end else if (rx_stall_left > 0) begin
         rsp_stall <= 1'b1;
         rx_stall_left--;
      end else if (rx_idle_pct != 0 && $urandom_range(99) < rx_idle_pct) begin
         rsp_stall <= 1'b1;
         rx_stall_left = idle_length() - 1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   initial begin
      #8000000;
      $display("Test completed with failures");
      $finish;
   end

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_stall = 1'b0;
      csr_write_enable = 1'b0;
      csr_index = CSR_FREQUENCY_THRESHOLD;
      csr_write_data = '0;
      cfg_freq_min = FREQUENCY_THRESHOLD_RESET;
      cfg_rocof_max = ROCOF_THRESHOLD_RESET;
      cfg_hold = HOLD_TICKS_RESET;
      pred_allowed = '0;
      pred_shed = '0;
      pred_managing = 1'b0;
      pred_maint = 1'b0;
      pred_was_unstable = 1'b0;
      pred_hold_count = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_threshold_edges();
      test_shed_restore();
      test_maintenance();
      test_long_hold();
      test_result_backpressure();
      test_random_settings();

      wait_idle();
      repeat (10) @(posedge clock);
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
